>>> src/ukrt_pkg.sv
package ukrt_pkg;

  localparam int REQ_W   = 3;
  localparam int KEY_W   = 34;
  localparam int DATA_W  = 64;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;

  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd5;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [KEY_W-1:0]  record_key;
    logic [DATA_W-1:0] record_data;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  found_slot;
    logic [KEY_W-1:0]   key_out;
    logic [DATA_W-1:0]  data_out;
    logic [COUNT_W-1:0] live_count;
  } rsp_t;

endpackage

>>> src/ukrt_ram.sv
module ukrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/unique_key_record_table_unit.sv
// Dense table of up to CAPACITY records, each a 34-bit key (unique through insert;
// slot write does not check it) and a 64-bit data word, held in slots 0 .. count-1
// of two single-port-read record memories. One request is taken at a time
// (req_ready is high only while the sequencer is idle) and gives exactly one
// response. Every key lookup walks the stored slots in order through one shared
// key comparator, one slot per cycle, limited by the single read port of the
// record memories; remove then compacts the table, moving each later record down
// one slot. A finished response waits in an output register, so the next request
// can be accepted while the previous response is still pending.
module unique_key_record_table_unit
  import ukrt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_READ   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;

  logic [CW-1:0]     count;
  logic [REQ_W-1:0]  op;
  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] data_q;
  logic [CW-1:0]     idx;
  logic              pend;
  logic [AW-1:0]     cmp_idx;

  logic              res_ok;
  logic [AW-1:0]     res_slot;
  logic [KEY_W-1:0]  res_key;
  logic [DATA_W-1:0] res_data;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [KEY_W-1:0]  wr_key;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [KEY_W-1:0]  rd_key;
  logic [DATA_W-1:0] rd_data;

  logic              accept;
  logic [CW+5:0]     slot_wide;
  logic [AW-1:0]     slot_addr;
  logic              slot_in_range;
  logic              more;
  logic              match;
  logic [AW+5:0]     res_slot_wide;
  logic [CW+6:0]     count_wide;

  assign req_ready     = (state == S_IDLE);
  assign accept        = req_valid && req_ready;
  assign slot_wide     = {{CW{1'b0}}, req.slot_index};
  assign slot_addr     = slot_wide[AW-1:0];
  assign slot_in_range = slot_wide < {6'b0, count};
  assign more          = idx < count;
  assign match         = pend && (rd_key == key_q);
  assign res_slot_wide = {6'b0, res_slot};
  assign count_wide    = {7'b0, count};

  // record memory ports
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmp_idx;
    wr_key  = rd_key;
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept && slot_in_range) begin
          if (req.req_type == REQ_READ) begin
            rd_en   = 1'b1;
            rd_addr = slot_addr;
          end else if (req.req_type == REQ_WRITE) begin
            wr_en   = 1'b1;
            wr_addr = slot_addr;
            wr_key  = req.record_key;
            wr_data = req.record_data;
          end
        end
      end
      S_SCAN: begin
        rd_en = more;
        if (op == REQ_INSERT && !match && !more) begin
          wr_en   = 1'b1;
          wr_addr = count[AW-1:0];
          wr_key  = key_q;
          wr_data = data_q;
        end
      end
      S_SHIFT: begin
        rd_en = more;
        wr_en = pend;
      end
      S_READ, S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op       <= req.req_type;
            key_q    <= req.record_key;
            data_q   <= req.record_data;
            idx      <= '0;
            pend     <= 1'b0;
            res_ok   <= 1'b0;
            res_slot <= '0;
            res_key  <= '0;
            res_data <= '0;
            state    <= S_FINISH;
            unique case (req.req_type) inside
              REQ_INSERT: begin
                if (count != CAP_COUNT) begin
                  state <= S_SCAN;
                end
              end
              REQ_REMOVE, REQ_SEARCH: begin
                state <= S_SCAN;
              end
              REQ_CLEAR: begin
                count  <= '0;
                res_ok <= 1'b1;
              end
              REQ_READ: begin
                if (slot_in_range) begin
                  res_slot <= slot_addr;
                  state    <= S_READ;
                end
              end
              REQ_WRITE: begin
                if (slot_in_range) begin
                  res_ok   <= 1'b1;
                  res_slot <= slot_addr;
                  res_key  <= req.record_key;
                  res_data <= req.record_data;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (more) begin
            idx     <= idx + 1'b1;
            cmp_idx <= idx[AW-1:0];
            pend    <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (match) begin
            if (op == REQ_INSERT) begin
              state <= S_FINISH;
            end else begin
              res_ok   <= 1'b1;
              res_slot <= cmp_idx;
              res_key  <= rd_key;
              res_data <= rd_data;
              if (op == REQ_REMOVE) begin
                // compaction: write slot cmp_idx from slot idx, one per cycle
                cmp_idx <= cmp_idx;
                idx     <= {{(CW-AW){1'b0}}, cmp_idx} + 1'b1;
                pend    <= 1'b0;
                state   <= S_SHIFT;
              end else begin
                state <= S_FINISH;
              end
            end
          end else if (!more) begin
            if (op == REQ_INSERT) begin
              res_ok   <= 1'b1;
              res_slot <= count[AW-1:0];
              res_key  <= key_q;
              res_data <= data_q;
              count    <= count + 1'b1;
            end
            state <= S_FINISH;
          end
        end
        S_SHIFT: begin
          if (pend) begin
            cmp_idx <= cmp_idx + 1'b1;
          end
          if (more) begin
            idx  <= idx + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count <= count - 1'b1;
              state <= S_FINISH;
            end
          end
        end
        S_READ: begin
          res_ok   <= 1'b1;
          res_key  <= rd_key;
          res_data <= rd_data;
          state    <= S_FINISH;
        end
        S_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!rsp_valid || rsp_ready)) begin
      rsp.ok         <= res_ok;
      rsp.found_slot <= res_slot_wide[SLOT_W-1:0];
      rsp.key_out    <= res_key;
      rsp.data_out   <= res_data;
      rsp.live_count <= count_wide[COUNT_W-1:0];
    end
  end

  ukrt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_key),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_key)
  );

  ukrt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_data_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import ukrt_pkg::*;

  localparam int TABLE_DEPTH    = 64;
  localparam int HOLD_LEN       = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int MAX_REPORTS    = 10;

  localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

  localparam logic [KEY_W-1:0]  KEY_ONES   = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0]  KEY_MAXDEC = 34'd9999999999;
  localparam logic [DATA_W-1:0] DATA_ONES  = {DATA_W{1'b1}};

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  unique_key_record_table_unit #(.CAPACITY(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // table model
  logic [KEY_W-1:0]  tbl_key  [TABLE_DEPTH];
  logic [DATA_W-1:0] tbl_data [TABLE_DEPTH];
  int tbl_count = 0;
  int peak_count = 0;
  int full_rejects = 0;

  rsp_t expected_rsp_q[$];
  dir_row_t dir_rows[$];

  int mismatches = 0;
  int items_sent = 0;
  int rsp_checked = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int holds_requested = 0;
  int holds_served = 0;
  int hold_left = 0;

  function automatic int lookup_slot(logic [KEY_W-1:0] k);
    int hit;
    hit = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (hit < 0 && tbl_key[i] == k) hit = i;
    end
    return hit;
  endfunction

  function automatic rsp_t mk_rsp(bit ok, int slot, logic [KEY_W-1:0] k,
                                  logic [DATA_W-1:0] d, int cnt);
    rsp_t o;
    o.ok = ok;
    o.found_slot = SLOT_W'(slot);
    o.key_out = k;
    o.data_out = d;
    o.live_count = COUNT_W'(cnt);
    return o;
  endfunction

  function automatic rsp_t predict_table(req_t r);
    rsp_t o;
    int hit;
    int slot;
    o = '0;
    slot = int'(r.slot_index);
    case (r.req_type)
      REQ_INSERT: begin
        hit = lookup_slot(r.record_key);
        if (hit < 0 && tbl_count >= TABLE_DEPTH) full_rejects++;
        if (hit < 0 && tbl_count < TABLE_DEPTH) begin
          tbl_key[tbl_count] = r.record_key;
          tbl_data[tbl_count] = r.record_data;
          o = mk_rsp(1'b1, tbl_count, r.record_key, r.record_data, 0);
          tbl_count++;
          if (tbl_count > peak_count) peak_count = tbl_count;
        end
      end
      REQ_REMOVE: begin
        hit = lookup_slot(r.record_key);
        if (hit >= 0) begin
          o = mk_rsp(1'b1, hit, tbl_key[hit], tbl_data[hit], 0);
          for (int i = hit; i + 1 < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_data[i] = tbl_data[i+1];
          end
          tbl_count--;
        end
      end
      REQ_SEARCH: begin
        hit = lookup_slot(r.record_key);
        if (hit >= 0) o = mk_rsp(1'b1, hit, tbl_key[hit], tbl_data[hit], 0);
      end
      REQ_CLEAR: begin
        tbl_count = 0;
        o = mk_rsp(1'b1, 0, '0, '0, 0);
      end
      REQ_READ: begin
        if (slot < tbl_count) o = mk_rsp(1'b1, slot, tbl_key[slot], tbl_data[slot], 0);
      end
      REQ_WRITE: begin
        if (slot < tbl_count) begin
          tbl_key[slot] = r.record_key;
          tbl_data[slot] = r.record_data;
          o = mk_rsp(1'b1, slot, r.record_key, r.record_data, 0);
        end
      end
      default: o = '0;
    endcase
    o.live_count = COUNT_W'(tbl_count);
    return o;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(int existing_pct);
    logic [63:0] wide;
    int roll;
    roll = $urandom_range(99);
    wide = {$urandom, $urandom};
    if (tbl_count > 0 && roll < existing_pct)
      return tbl_key[$urandom_range(tbl_count - 1)];
    else if (roll < existing_pct + 25)
      return KEY_W'($urandom_range(255));
    else if (roll < existing_pct + 45)
      return KEY_W'(wide % 64'd10000000000);
    else
      return KEY_W'(wide);
  endfunction

  function automatic req_t build_random_req(mix_t mix);
    req_t r;
    int roll;
    int ins_lim, srch_lim, rd_lim, wr_lim, rm_lim, clr_lim;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        ins_lim = 75; srch_lim = 81; rd_lim = 87; wr_lim = 93; rm_lim = 99; clr_lim = 99;
      end
      MIX_DRAIN: begin
        ins_lim = 15; srch_lim = 28; rd_lim = 40; wr_lim = 46; rm_lim = 97; clr_lim = 98;
      end
      default: begin
        ins_lim = 30; srch_lim = 45; rd_lim = 60; wr_lim = 70; rm_lim = 90; clr_lim = 93;
      end
    endcase
    if (roll < ins_lim) r.req_type = REQ_INSERT;
    else if (roll < srch_lim) r.req_type = REQ_SEARCH;
    else if (roll < rd_lim) r.req_type = REQ_READ;
    else if (roll < wr_lim) r.req_type = REQ_WRITE;
    else if (roll < rm_lim) r.req_type = REQ_REMOVE;
    else if (roll < clr_lim) r.req_type = REQ_CLEAR;
    else r.req_type = ($urandom_range(1) != 0) ? REQ_SPARE7 : REQ_SPARE6;
    r.record_key = pick_key((r.req_type == REQ_INSERT) ? 20 : 60);
    roll = $urandom_range(99);
    if (roll < 10) r.record_data = DATA_ONES;
    else if (roll < 20) r.record_data = '0;
    else r.record_data = {$urandom, $urandom};
    if (tbl_count > 0 && $urandom_range(99) < 75)
      r.slot_index = SLOT_W'($urandom_range(tbl_count - 1));
    else
      r.slot_index = SLOT_W'($urandom_range(63));
    return r;
  endfunction

  function automatic void add_row(logic [REQ_W-1:0] op, logic [KEY_W-1:0] k,
                                  logic [DATA_W-1:0] d, int slot, bit typed, rsp_t want);
    dir_row_t row;
    row.r.req_type = op;
    row.r.record_key = k;
    row.r.record_data = d;
    row.r.slot_index = SLOT_W'(slot);
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic void report_mismatch(string what, rsp_t want, rsp_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%t %s: want ok=%0d slot=%0d key=%h data=%h cnt=%0d, got ok=%0d slot=%0d key=%h data=%h cnt=%0d",
               $realtime, what, want.ok, want.found_slot, want.key_out, want.data_out,
               want.live_count, got.ok, got.found_slot, got.key_out, got.data_out,
               got.live_count);
  endfunction

  task automatic send_item(req_t r, bit typed, rsp_t want);
    rsp_t pred;
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    pred = predict_table(r);
    expected_rsp_q.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // response side: check each transaction, then decide next ready
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_checked++;
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected response", '0, rsp);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.ok !== want.ok || rsp.found_slot !== want.found_slot ||
              rsp.key_out !== want.key_out || rsp.data_out !== want.data_out ||
              rsp.live_count !== want.live_count)
            report_mismatch("response mismatch", want, rsp);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (holds_served != holds_requested) begin
        holds_served++;
        hold_left = HOLD_LEN;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int idle_by_phase [4];
    int stall_by_phase [4];
    idle_by_phase = '{0, 57, 0, 21};
    stall_by_phase = '{0, 0, 57, 21};

    // directed rows, typed results where obvious
    add_row(REQ_SEARCH, '0, '0, 0, 1, mk_rsp(0, 0, '0, '0, 0));
    add_row(REQ_READ, '0, '0, 0, 1, mk_rsp(0, 0, '0, '0, 0));
    add_row(REQ_WRITE, 34'd5, 64'd5, 0, 1, mk_rsp(0, 0, '0, '0, 0));
    add_row(REQ_REMOVE, '0, '0, 0, 1, mk_rsp(0, 0, '0, '0, 0));
    add_row(REQ_SPARE6, KEY_ONES, DATA_ONES, 63, 1, mk_rsp(0, 0, '0, '0, 0));
    add_row(REQ_SPARE7, KEY_ONES, DATA_ONES, 63, 1, mk_rsp(0, 0, '0, '0, 0));
    add_row(REQ_INSERT, KEY_ONES, DATA_ONES, 63, 1, mk_rsp(1, 0, KEY_ONES, DATA_ONES, 1));
    add_row(REQ_INSERT, '0, '0, 0, 1, mk_rsp(1, 1, '0, '0, 2));
    add_row(REQ_INSERT, KEY_ONES, 64'd1, 0, 1, mk_rsp(0, 0, '0, '0, 2));
    add_row(REQ_SEARCH, '0, DATA_ONES, 63, 1, mk_rsp(1, 1, '0, '0, 2));
    add_row(REQ_READ, '0, '0, 63, 1, mk_rsp(0, 0, '0, '0, 2));
    add_row(REQ_READ, '0, '0, 2, 1, mk_rsp(0, 0, '0, '0, 2));
    add_row(REQ_READ, '0, '0, 0, 1, mk_rsp(1, 0, KEY_ONES, DATA_ONES, 2));
    add_row(REQ_WRITE, KEY_MAXDEC, 64'h5555_5555_5555_5555, 1, 1,
            mk_rsp(1, 1, KEY_MAXDEC, 64'h5555_5555_5555_5555, 2));
    add_row(REQ_INSERT, 34'h2_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 42, 1,
            mk_rsp(1, 2, 34'h2_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 3));
    // duplicate key through slot write
    add_row(REQ_WRITE, KEY_ONES, 64'h0123_4567_89AB_CDEF, 2, 1,
            mk_rsp(1, 2, KEY_ONES, 64'h0123_4567_89AB_CDEF, 3));
    add_row(REQ_SEARCH, KEY_ONES, '0, 0, 0, '0);
    add_row(REQ_REMOVE, KEY_ONES, '0, 0, 0, '0);
    add_row(REQ_READ, '0, '0, 0, 0, '0);
    add_row(REQ_SEARCH, KEY_ONES, '0, 0, 0, '0);
    add_row(REQ_REMOVE, KEY_MAXDEC, '0, 0, 0, '0);
    add_row(REQ_CLEAR, KEY_ONES, DATA_ONES, 63, 1, mk_rsp(1, 0, '0, '0, 0));
    add_row(REQ_READ, '0, '0, 0, 1, mk_rsp(0, 0, '0, '0, 0));
    add_row(REQ_INSERT, 34'h1_5555_5555, '0, 21, 1, mk_rsp(1, 0, 34'h1_5555_5555, '0, 1));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_by_phase[ph];
      stall_pct <= stall_by_phase[ph];
      repeat (160) send_item(build_random_req(MIX_FILL), 0, '0);
      repeat (70) send_item(build_random_req(MIX_BALANCED), 0, '0);
      repeat (100) send_item(build_random_req(MIX_DRAIN), 0, '0);
    end

    // receiver holds off while requests keep coming
    idle_pct = 0;
    stall_pct <= 0;
    holds_requested <= holds_requested + 1;
    repeat (60) send_item(build_random_req(MIX_BALANCED), 0, '0);

    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests over four idle mixes plus a long output hold, %0d responses checked",
             items_sent, rsp_checked);
    $display("peak occupancy %0d of %0d, %0d inserts rejected on a full table",
             peak_count, TABLE_DEPTH, full_rejects);
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> unique_key_record_table_unit.f
src/ukrt_pkg.sv
src/ukrt_ram.sv
src/unique_key_record_table_unit.sv
verif/tb.sv
